/* hdl/sirm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirm_pkg
// Shared sizes, codes and types of the service instance registry.
// ----------------------------------------------------------------------------
package sirm_pkg;

    localparam int NUM_INSTANCES     = 16;
    localparam int NUM_SERVICES      = 16;
    localparam int SLOTS_PER_SERVICE = 8;

    // fixed field widths
    localparam int ACT_W  = 2;
    localparam int SVC_IN_W = 4;
    localparam int ID_IN_W  = 4;
    localparam int HASH_W = 32;
    localparam int CH_W   = 5;
    localparam int ST_W   = 3;

    // derived widths
    localparam int ID_W    = $clog2(NUM_INSTANCES);
    localparam int NID_W   = ($clog2(NUM_INSTANCES + 2) > ID_IN_W) ?
                             $clog2(NUM_INSTANCES + 2) : ID_IN_W + 1;
    localparam int SVC_W   = (NUM_SERVICES > 1) ? $clog2(NUM_SERVICES) : 1;
    localparam int SLOT_W  = (SLOTS_PER_SERVICE > 1) ? $clog2(SLOTS_PER_SERVICE) : 1;
    localparam int CNT_W   = $clog2(SLOTS_PER_SERVICE + 1);
    localparam int ADDR_W  = SVC_W + SLOT_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int FIFO_DEPTH = 2;

    // action codes
    localparam logic [ACT_W-1:0] ACT_START  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_STOP   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_NO_IDS    = 3'd1;
    localparam logic [ST_W-1:0] ST_CONFLICT  = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd4;

    localparam logic [CH_W-1:0] CHOSEN_NONE = CH_W'(NUM_INSTANCES);

    typedef enum logic [1:0] {
        K_START,
        K_STOP,
        K_LOOKUP,
        K_NONE
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [SVC_IN_W-1:0]  svc;
        logic [ID_IN_W-1:0]   id;
        logic                 auto_id;
        logic [HASH_W-1:0]    hash;
        logic                 svc_ok;
        logic                 id_ok;
    } t_cmd;

endpackage

/* hdl/service_instance_registry_map_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// service_instance_registry_map_top
// Service to instance registry for packet steering: start, stop, lookup.
//
//  Channel   Dir  tdata                                   tuser
//  s_axis    in   [3:0] svc_num, [7:4] inst_num,          [1:0] action
//                 [8] auto_id, [40:9] flow_hash
//  m_axis    out  [4:0] chosen_instance                   [2:0] status
//
// The executor takes one word at a time, from dequeue to the result
// register. Start: a requested id is checked and written directly; the
// automatic scan first steps past each occupied id. Stop: list entries
// are read and compared until the hit, then later entries shift down.
// Lookup: a one-bit-per-cycle remainder over the 32-bit hash picks the
// entry; an empty list skips it. The front register and a two-deep queue
// keep accepting while the executor works, until the queue fills; the
// executor waits in its response step only while the previous result is
// still unaccepted. Synchronous active-low reset; no clearing pass needed.
// ----------------------------------------------------------------------------
module service_instance_registry_map_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // svc_num, inst_num, auto_id, flow_hash
    input  logic [1:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // chosen_instance
    output logic [2:0]  m_axis_tuser    // status
);

    logic           w_f_valid;
    logic           w_f_ready;
    sirm_pkg::t_cmd w_f_cmd;
    logic           w_q_valid;
    logic           w_q_pop;
    sirm_pkg::t_cmd w_q_cmd;
    logic [sirm_pkg::CH_W-1:0] w_chosen;

    sirm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_action    (s_axis_tuser),
        .i_svc       (s_axis_tdata[3:0]),
        .i_id        (s_axis_tdata[7:4]),
        .i_auto_id   (s_axis_tdata[8]),
        .i_hash      (s_axis_tdata[40:9]),
        .o_cmd_valid (w_f_valid),
        .i_cmd_ready (w_f_ready),
        .o_cmd       (w_f_cmd)
    );

    sirm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .o_ready (w_f_ready),
        .i_cmd   (w_f_cmd),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_cmd   (w_q_cmd)
    );

    sirm_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_pop   (w_q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_chosen    (w_chosen),
        .o_status    (m_axis_tuser)
    );

    assign m_axis_tdata = {3'b000, w_chosen};

endmodule

/* hdl/sirm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirm_front
// Accepts input words, decodes the action and range checks, registers the
// command for the queue.
// ----------------------------------------------------------------------------
module sirm_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [sirm_pkg::ACT_W-1:0]       i_action,
    input  logic [sirm_pkg::SVC_IN_W-1:0]    i_svc,
    input  logic [sirm_pkg::ID_IN_W-1:0]     i_id,
    input  logic                             i_auto_id,
    input  logic [sirm_pkg::HASH_W-1:0]      i_hash,
    output logic                             o_cmd_valid,
    input  logic                             i_cmd_ready,
    output sirm_pkg::t_cmd                   o_cmd
);

    logic           r_valid;
    sirm_pkg::t_cmd r_cmd;
    sirm_pkg::t_kind w_kind;
    logic           w_accept;

    always_comb begin
        unique case (i_action)
            sirm_pkg::ACT_START:  w_kind = sirm_pkg::K_START;
            sirm_pkg::ACT_STOP:   w_kind = sirm_pkg::K_STOP;
            sirm_pkg::ACT_LOOKUP: w_kind = sirm_pkg::K_LOOKUP;
            default:              w_kind = sirm_pkg::K_NONE;
        endcase
    end

    assign o_ready  = !r_valid || i_cmd_ready;
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_valid        <= 1'b1;
                r_cmd.kind     <= w_kind;
                r_cmd.svc      <= i_svc;
                r_cmd.id       <= i_id;
                r_cmd.auto_id  <= i_auto_id;
                r_cmd.hash     <= i_hash;
                r_cmd.svc_ok   <= 32'(i_svc) < sirm_pkg::NUM_SERVICES;
                r_cmd.id_ok    <= 32'(i_id) < sirm_pkg::NUM_INSTANCES;
            end else if (i_cmd_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

/* hdl/sirm_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirm_fifo
// Short command queue between the front end and the executor.
// ----------------------------------------------------------------------------
module sirm_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_ready,
    input  sirm_pkg::t_cmd  i_cmd,
    output logic            o_valid,
    input  logic            i_pop,
    output sirm_pkg::t_cmd  o_cmd
);

    localparam int PTR_W = (sirm_pkg::FIFO_DEPTH > 1) ? $clog2(sirm_pkg::FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(sirm_pkg::FIFO_DEPTH + 1);

    sirm_pkg::t_cmd     r_buf [sirm_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [CNT_W-1:0]   r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_ready = r_cnt != CNT_W'(sirm_pkg::FIFO_DEPTH);
    assign o_valid = r_cnt != '0;
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;
    assign o_cmd   = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PTR_W'(sirm_pkg::FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PTR_W'(sirm_pkg::FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* hdl/sirm_mod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirm_mod
// Bit-serial remainder of the flow hash by a small list length.
// ----------------------------------------------------------------------------
module sirm_mod (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [sirm_pkg::HASH_W-1:0]    i_dividend,
    input  logic [sirm_pkg::CNT_W-1:0]     i_divisor,
    output logic                           o_done,
    output logic [sirm_pkg::CNT_W-1:0]     o_rem
);

    localparam int W    = sirm_pkg::CNT_W;
    localparam int IT_W = $clog2(sirm_pkg::HASH_W);

    logic                        r_busy;
    logic                        r_done;
    logic [IT_W-1:0]             r_it;
    logic [sirm_pkg::HASH_W-1:0] r_q;
    logic [W-1:0]                r_rem;
    logic [W-1:0]                r_div;
    logic [W:0]                  w_trial;
    logic [W:0]                  w_next;

    assign w_trial = {r_rem, r_q[sirm_pkg::HASH_W-1]};
    assign w_next  = (w_trial >= {1'b0, r_div}) ? w_trial - {1'b0, r_div} : w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_it   <= IT_W'(sirm_pkg::HASH_W - 1);
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_next[W-1:0];
                r_q   <= {r_q[sirm_pkg::HASH_W-2:0], 1'b0};
                r_it  <= r_it - 1'b1;
                if (r_it == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* hdl/sirm_exec.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirm_exec
// Executes queued commands: id scan and occupancy, per-service lists in a
// memory, list compaction on stop, hash selection on lookup.
// ----------------------------------------------------------------------------
module sirm_exec (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  sirm_pkg::t_cmd                i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [sirm_pkg::CH_W-1:0]     o_chosen,
    output logic [sirm_pkg::ST_W-1:0]     o_status
);

    localparam int N      = sirm_pkg::NUM_INSTANCES;
    localparam int ID_W   = sirm_pkg::ID_W;
    localparam int NID_W  = sirm_pkg::NID_W;
    localparam int SVC_W  = sirm_pkg::SVC_W;
    localparam int SLOT_W = sirm_pkg::SLOT_W;
    localparam int CNT_W  = sirm_pkg::CNT_W;
    localparam int ADDR_W = sirm_pkg::ADDR_W;
    localparam int CH_W   = sirm_pkg::CH_W;
    localparam int ST_W   = sirm_pkg::ST_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_START,
        S_SRD,
        S_SCMP,
        S_SHRD,
        S_SHWR,
        S_MOD,
        S_LKRD,
        S_LKDATA,
        S_RESP
    } t_state;

    t_state             r_state;
    sirm_pkg::t_cmd     r_cmd;
    logic [N-1:0]       r_occ;
    logic [CNT_W-1:0]   r_cnt [sirm_pkg::NUM_SERVICES];
    logic [NID_W-1:0]   r_next_id;
    logic [NID_W-1:0]   r_ptr;
    logic [CNT_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_n;
    logic [CH_W-1:0]    r_chosen;
    logic [ST_W-1:0]    r_status;
    logic               r_out_valid;
    logic [CH_W-1:0]    r_out_chosen;
    logic [ST_W-1:0]    r_out_status;
    logic [ID_W-1:0]    r_mem [sirm_pkg::MEM_DEPTH];
    logic [ID_W-1:0]    r_rdata;

    logic [SVC_W-1:0]   w_svc;
    logic [CNT_W-1:0]   w_cnt;
    logic [SVC_W-1:0]   w_in_svc;
    logic [CNT_W-1:0]   w_in_cnt;
    logic [ID_W-1:0]    w_occ_idx;
    logic               w_ptr_in;
    logic               w_occ_ptr;
    logic               w_start_ok;
    logic               w_hit;
    logic [CNT_W-1:0]   w_rslot;
    logic [ADDR_W-1:0]  w_raddr;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [ID_W-1:0]    w_wdata;
    logic               w_mod_start;
    logic               w_mod_done;
    logic [CNT_W-1:0]   w_mod_rem;

    assign w_svc      = SVC_W'(r_cmd.svc);
    assign w_cnt      = r_cnt[w_svc];
    assign w_in_svc   = SVC_W'(i_cmd.svc);
    assign w_in_cnt   = r_cnt[w_in_svc];
    assign w_occ_idx  = ID_W'(r_ptr);
    assign w_ptr_in   = r_ptr < NID_W'(N);
    assign w_occ_ptr  = r_occ[w_occ_idx];
    assign w_start_ok = w_ptr_in && !w_occ_ptr && r_cmd.svc_ok &&
                        (w_cnt < CNT_W'(sirm_pkg::SLOTS_PER_SERVICE));
    assign w_hit      = r_rdata == ID_W'(r_cmd.id);
    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_valid;

    assign w_mod_start = o_cmd_pop && (i_cmd.kind == sirm_pkg::K_LOOKUP) &&
                         i_cmd.svc_ok && (w_in_cnt != '0);

    sirm_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (i_cmd.hash),
        .i_divisor  (w_in_cnt),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    // list memory ports
    assign w_rslot = (r_state == S_SHRD) ? r_idx + 1'b1 : r_idx;
    assign w_raddr = {w_svc, SLOT_W'(w_rslot)};
    assign w_we    = ((r_state == S_START) && w_start_ok) || (r_state == S_SHWR);
    assign w_waddr = (r_state == S_START) ? {w_svc, SLOT_W'(w_cnt)} : {w_svc, SLOT_W'(r_idx)};
    assign w_wdata = (r_state == S_START) ? w_occ_idx : r_rdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_occ       <= '0;
            r_next_id   <= '0;
            r_cmd       <= '0;
            for (int s = 0; s < sirm_pkg::NUM_SERVICES; s++) begin
                r_cnt[s] <= '0;
            end
        end else begin
            if (r_out_valid && i_ready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_idx <= '0;
                        r_n   <= w_in_cnt;
                        case (i_cmd.kind)
                            sirm_pkg::K_START: begin
                                if (i_cmd.auto_id) begin
                                    r_ptr   <= (r_next_id >= NID_W'(N)) ? NID_W'(1) : r_next_id;
                                    r_state <= S_SCAN;
                                end else begin
                                    r_ptr   <= NID_W'(i_cmd.id);
                                    r_state <= S_START;
                                end
                            end
                            sirm_pkg::K_STOP: begin
                                if (i_cmd.id_ok) begin
                                    r_occ[ID_W'(i_cmd.id)] <= 1'b0;
                                end
                                if (!i_cmd.svc_ok || !i_cmd.id_ok || w_in_cnt == '0) begin
                                    r_chosen <= sirm_pkg::CHOSEN_NONE;
                                    r_status <= sirm_pkg::ST_NOT_FOUND;
                                    r_state  <= S_RESP;
                                end else begin
                                    r_state <= S_SRD;
                                end
                            end
                            sirm_pkg::K_LOOKUP: begin
                                if (!i_cmd.svc_ok || w_in_cnt == '0) begin
                                    r_chosen <= '0;
                                    r_status <= sirm_pkg::ST_NOT_FOUND;
                                    r_state  <= S_RESP;
                                end else begin
                                    r_state <= S_MOD;
                                end
                            end
                            default: begin
                                r_chosen <= sirm_pkg::CHOSEN_NONE;
                                r_status <= sirm_pkg::ST_NOT_FOUND;
                                r_state  <= S_RESP;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_ptr_in && w_occ_ptr) begin
                        r_ptr <= r_ptr + 1'b1;
                    end else begin
                        r_next_id <= r_ptr + 1'b1;
                        r_state   <= S_START;
                    end
                end
                S_START: begin
                    if (!w_ptr_in) begin
                        r_chosen <= sirm_pkg::CHOSEN_NONE;
                        r_status <= sirm_pkg::ST_NO_IDS;
                    end else if (w_occ_ptr) begin
                        r_chosen <= CH_W'(r_ptr);
                        r_status <= sirm_pkg::ST_CONFLICT;
                    end else if (!w_start_ok) begin
                        r_chosen <= CH_W'(r_ptr);
                        r_status <= sirm_pkg::ST_FULL;
                    end else begin
                        r_chosen         <= CH_W'(r_ptr);
                        r_occ[w_occ_idx] <= 1'b1;
                        r_cnt[w_svc]     <= w_cnt + 1'b1;
                        r_status         <= sirm_pkg::ST_OK;
                    end
                    r_state <= S_RESP;
                end
                S_SRD: begin
                    r_state <= S_SCMP;
                end
                S_SCMP: begin
                    if (w_hit) begin
                        r_chosen     <= CH_W'(r_cmd.id);
                        r_status     <= sirm_pkg::ST_OK;
                        r_cnt[w_svc] <= r_n - 1'b1;
                        r_state      <= (r_idx + 1'b1 < r_n) ? S_SHRD : S_RESP;
                    end else if (r_idx + 1'b1 == r_n) begin
                        r_chosen <= sirm_pkg::CHOSEN_NONE;
                        r_status <= sirm_pkg::ST_NOT_FOUND;
                        r_state  <= S_RESP;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SRD;
                    end
                end
                S_SHRD: begin
                    r_state <= S_SHWR;
                end
                S_SHWR: begin
                    r_idx   <= r_idx + 1'b1;
                    r_state <= (r_idx + CNT_W'(2) < r_n) ? S_SHRD : S_RESP;
                end
                S_MOD: begin
                    if (w_mod_done) begin
                        r_idx   <= w_mod_rem;
                        r_state <= S_LKRD;
                    end
                end
                S_LKRD: begin
                    r_state <= S_LKDATA;
                end
                S_LKDATA: begin
                    r_chosen <= CH_W'(r_rdata);
                    r_status <= sirm_pkg::ST_OK;
                    r_state  <= S_RESP;
                end
                S_RESP: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_chosen <= r_chosen;
                        r_out_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_out_valid;
    assign o_chosen = r_out_chosen;
    assign o_status = r_out_status;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt <= CNT_W'(sirm_pkg::SLOTS_PER_SERVICE))
        else $error("service count beyond slot limit");

    a_start_occupies: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START && w_start_ok) |=> r_occ[$past(w_occ_idx)])
        else $error("accepted start did not mark id occupied");

    a_stop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCMP && w_hit) |=> r_cnt[$past(w_svc)] == $past(r_n) - 1'b1)
        else $error("stop hit did not shrink the list");

    a_mod_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> r_state == S_MOD)
        else $error("remainder finished outside lookup");

    a_out_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_RESP))
        else $error("result word loaded outside response state");
`endif

endmodule
